// ===== hdl/tbde_pkg.sv =====
// Shared types, codes and reset values for the trackball direction event block.
`default_nettype none

package tbde_pkg;

   // Field widths fixed by the poll word.
   localparam int unsigned TIME_BITS  = 32;
   localparam int unsigned PULSE_BITS = 15;
   localparam int unsigned MOD_BITS   = 4;
   localparam int unsigned THR_BITS   = 7;
   localparam int unsigned DEB_BITS   = 8;
   localparam int unsigned REQ_BYTES  = 13;
   localparam int unsigned RSP_BYTES  = 1;
   localparam int unsigned CSR_DATA_BITS = 8;

   // Default accumulator width.
   localparam int unsigned ACC_BITS_DEFAULT = 18;

   // Register reset values.
   localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 7'd3;
   localparam logic                MODE_RESET      = 1'b0;
   localparam logic [DEB_BITS-1:0] DEBOUNCE_RESET  = 8'd30;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_MODE      = 2'd1,
      CSR_DEBOUNCE  = 2'd2
   } csr_index_type;

   // Key codes of the result word.
   typedef enum logic [2:0] {
      EV_ENTER = 3'd0,
      EV_UP    = 3'd1,
      EV_DOWN  = 3'd2,
      EV_LEFT  = 3'd3,
      EV_RIGHT = 3'd4
   } key_type;

   // One poll; first member lands in the highest bits, so now_ms sits at bit 0.
   typedef struct packed {
      logic [MOD_BITS-1:0]   modifier_flags;
      logic [PULSE_BITS-1:0] right_pulses;
      logic [PULSE_BITS-1:0] left_pulses;
      logic [PULSE_BITS-1:0] down_pulses;
      logic [PULSE_BITS-1:0] up_pulses;
      logic                  right_level;
      logic                  left_level;
      logic                  down_level;
      logic                  up_level;
      logic                  click_down;
      logic [TIME_BITS-1:0]  now_ms;
   } req_type;

   // One result; event_valid sits at bit 0.
   typedef struct packed {
      logic [MOD_BITS-1:0] event_modifiers;
      key_type             key_code;
      logic                event_valid;
   } rsp_type;

   // Click debounce and edge-detect state carried from poll to poll.
   typedef struct packed {
      logic                 click_held;
      logic                 click_fired;
      logic [TIME_BITS-1:0] click_start_ms;
      logic                 first_poll;
      logic [3:0]           last_levels;
   } ctl_type;

   localparam ctl_type CTL_RESET = '{
      click_held:     1'b0,
      click_fired:    1'b0,
      click_start_ms: '0,
      first_poll:     1'b1,
      last_levels:    4'd0
   };

endpackage : tbde_pkg

`default_nettype wire

// ===== hdl/tbde_step.sv =====
// Combinational step: debounce, edge detect, saturating accumulate and direction checks.
`default_nettype none

module tbde_step
   import tbde_pkg::*;
#(
   parameter int unsigned ACC_BITS = ACC_BITS_DEFAULT
) (
   input  wire req_type                  item,
   input  wire ctl_type                  ctl,
   input  wire logic signed [ACC_BITS-1:0] acc_x,
   input  wire logic signed [ACC_BITS-1:0] acc_y,
   input  wire logic [THR_BITS-1:0]      move_threshold,
   input  wire logic                     count_mode,
   input  wire logic [DEB_BITS-1:0]      debounce_ms,
   output rsp_type                       rsp,
   output ctl_type                       ctl_next,
   output logic signed [ACC_BITS-1:0]    acc_x_next,
   output logic signed [ACC_BITS-1:0]    acc_y_next
);

   // Sum width covers the accumulator and a signed pulse difference plus carry.
   localparam int unsigned SUM_BITS =
      ((ACC_BITS > PULSE_BITS + 1) ? ACC_BITS : PULSE_BITS + 1) + 1;
   localparam logic signed [SUM_BITS-1:0] ACC_MAX =
      {{(SUM_BITS-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] ACC_MIN =
      {{(SUM_BITS-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};

   logic                       click_event;
   logic                       skip;
   logic [3:0]                 levels;
   logic [3:0]                 edges;
   logic [TIME_BITS-1:0]       hold_ms;
   logic signed [SUM_BITS-1:0] dx;
   logic signed [SUM_BITS-1:0] dy;
   logic signed [SUM_BITS-1:0] sum_x;
   logic signed [SUM_BITS-1:0] sum_y;
   logic signed [SUM_BITS-1:0] sat_x;
   logic signed [SUM_BITS-1:0] sat_y;
   logic signed [SUM_BITS-1:0] th_pos;
   logic signed [SUM_BITS-1:0] th_neg;

   assign levels  = {item.right_level, item.left_level, item.down_level, item.up_level};
   assign edges   = levels & ~ctl.last_levels;
   assign hold_ms = item.now_ms - ctl.click_start_ms;
   assign th_pos  = $signed({{(SUM_BITS-THR_BITS){1'b0}}, move_threshold});
   assign th_neg  = -th_pos;

   // Net step per axis: pulse counts in interrupt mode, new edges in level mode.
   always_comb begin
      if (count_mode) begin
         dy = $signed({{(SUM_BITS-PULSE_BITS){1'b0}}, item.down_pulses})
            - $signed({{(SUM_BITS-PULSE_BITS){1'b0}}, item.up_pulses});
         dx = $signed({{(SUM_BITS-PULSE_BITS){1'b0}}, item.right_pulses})
            - $signed({{(SUM_BITS-PULSE_BITS){1'b0}}, item.left_pulses});
      end else begin
         dy = $signed({{(SUM_BITS-1){1'b0}}, edges[1]})
            - $signed({{(SUM_BITS-1){1'b0}}, edges[0]});
         dx = $signed({{(SUM_BITS-1){1'b0}}, edges[3]})
            - $signed({{(SUM_BITS-1){1'b0}}, edges[2]});
      end
   end

   // Add and clamp to the signed accumulator range.
   assign sum_y = $signed({{(SUM_BITS-ACC_BITS){acc_y[ACC_BITS-1]}}, acc_y}) + dy;
   assign sum_x = $signed({{(SUM_BITS-ACC_BITS){acc_x[ACC_BITS-1]}}, acc_x}) + dx;

   always_comb begin
      sat_y = sum_y;
      if (sum_y > ACC_MAX) sat_y = ACC_MAX;
      if (sum_y < ACC_MIN) sat_y = ACC_MIN;
      sat_x = sum_x;
      if (sum_x > ACC_MAX) sat_x = ACC_MAX;
      if (sum_x < ACC_MIN) sat_x = ACC_MIN;
   end

   // Click debounce, first-poll capture, then direction checks in priority order.
   always_comb begin
      ctl_next    = ctl;
      click_event = 1'b0;
      skip        = 1'b0;
      acc_x_next  = acc_x;
      acc_y_next  = acc_y;
      rsp         = '{event_modifiers: '0, key_code: EV_ENTER, event_valid: 1'b0};

      if (item.click_down) begin
         if (!ctl.click_held) begin
            ctl_next.click_held     = 1'b1;
            ctl_next.click_start_ms = item.now_ms;
            ctl_next.click_fired    = 1'b0;
         end else if (!ctl.click_fired &&
                      hold_ms >= {{(TIME_BITS-DEB_BITS){1'b0}}, debounce_ms}) begin
            ctl_next.click_fired = 1'b1;
            click_event          = 1'b1;
         end
      end else begin
         ctl_next.click_held  = 1'b0;
         ctl_next.click_fired = 1'b0;
      end

      // Level mode records the lines on every poll; the first poll only records.
      if (!count_mode) begin
         ctl_next.last_levels = levels;
         if (ctl.first_poll) begin
            ctl_next.first_poll = 1'b0;
            skip                = 1'b1;
         end
      end

      if (skip) begin
         rsp.event_valid = 1'b0;
      end else if (click_event) begin
         rsp = '{event_modifiers: item.modifier_flags, key_code: EV_ENTER,
                 event_valid: 1'b1};
      end else begin
         acc_x_next = sat_x[ACC_BITS-1:0];
         acc_y_next = sat_y[ACC_BITS-1:0];
         if (sat_y <= th_neg) begin
            acc_y_next = '0;
            rsp = '{event_modifiers: item.modifier_flags, key_code: EV_UP,
                    event_valid: 1'b1};
         end else if (sat_y >= th_pos) begin
            acc_y_next = '0;
            rsp = '{event_modifiers: item.modifier_flags, key_code: EV_DOWN,
                    event_valid: 1'b1};
         end else if (sat_x <= th_neg) begin
            acc_x_next = '0;
            rsp = '{event_modifiers: item.modifier_flags, key_code: EV_LEFT,
                    event_valid: 1'b1};
         end else if (sat_x >= th_pos) begin
            acc_x_next = '0;
            rsp = '{event_modifiers: item.modifier_flags, key_code: EV_RIGHT,
                    event_valid: 1'b1};
         end
      end
   end

endmodule : tbde_step

`default_nettype wire

// ===== hdl/trackball_direction_events_top.sv =====
// Top level of the trackball direction event block: registers, handshakes and step logic.
//
//   Channel  Direction  Ports                           Word contents (lowest bit up)
//   req      in         req_tvalid/tready/tdata[103:0]  poll fields, 3 pad bits
//   rsp      out        rsp_tvalid/tready/tdata[7:0]    event_valid, key_code, event_modifiers
//   csr      in         csr_we/index[1:0]/wdata[7:0]    threshold, mode, debounce
//
// Each poll word is registered on acceptance and then passes through the step logic
// into the result register once that register is free or draining.
// One poll per cycle is sustained while rsp_tready holds; the combinational step sets it.
// Reset is synchronous and clears the handshake, debounce and accumulator state.
// A stalled result holds the step, and a held input word then stalls the input side.
`default_nettype none

module trackball_direction_events_top
   import tbde_pkg::*;
#(
   parameter int unsigned ACC_BITS = ACC_BITS_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   // now_ms, click_down, up_level, down_level, left_level, right_level,
   // up_pulses, down_pulses, left_pulses, right_pulses, modifier_flags
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [8*REQ_BYTES-1:0]         req_tdata,
   // event_valid, key_code, event_modifiers
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [8*RSP_BYTES-1:0]         rsp_tdata,
   input  wire                            csr_we,
   input  wire  [1:0]                     csr_index,
   input  wire  [CSR_DATA_BITS-1:0]       csr_wdata
);

   localparam int unsigned REQ_BITS = $bits(req_type);

   req_type                     in_word_ff;
   logic                        in_valid_ff;
   logic                        in_valid_in;
   rsp_type                     out_word_ff;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   ctl_type                     ctl_ff;
   ctl_type                     ctl_in;
   logic signed [ACC_BITS-1:0]  acc_x_ff;
   logic signed [ACC_BITS-1:0]  acc_y_ff;
   logic signed [ACC_BITS-1:0]  acc_x_in;
   logic signed [ACC_BITS-1:0]  acc_y_in;
   logic [THR_BITS-1:0]         threshold_ff;
   logic                        mode_ff;
   logic [DEB_BITS-1:0]         debounce_ff;
   logic                        step_go;
   logic                        mode_clear;
   rsp_type                     step_rsp;
   ctl_type                     step_ctl;
   logic signed [ACC_BITS-1:0]  step_acc_x;
   logic signed [ACC_BITS-1:0]  step_acc_y;

   // The step runs whenever a word is held and the result register is free or draining.
   assign step_go    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_go;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = step_go ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   // A mode write that changes the mode clears both accumulators.
   assign mode_clear = csr_we && (csr_index == CSR_MODE) && (csr_wdata[0] != mode_ff);

   tbde_step #(
      .ACC_BITS(ACC_BITS)
   ) u_step (
      .item           (in_word_ff),
      .ctl            (ctl_ff),
      .acc_x          (acc_x_ff),
      .acc_y          (acc_y_ff),
      .move_threshold (threshold_ff),
      .count_mode     (mode_ff),
      .debounce_ms    (debounce_ff),
      .rsp            (step_rsp),
      .ctl_next       (step_ctl),
      .acc_x_next     (step_acc_x),
      .acc_y_next     (step_acc_y)
   );

   // Next state of the poll-to-poll state.
   always_comb begin
      ctl_in   = step_go ? step_ctl : ctl_ff;
      acc_x_in = step_go ? step_acc_x : acc_x_ff;
      acc_y_in = step_go ? step_acc_y : acc_y_ff;
      if (mode_clear) begin
         acc_x_in = '0;
         acc_y_in = '0;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctl_ff       <= CTL_RESET;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ctl_ff       <= ctl_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         mode_ff      <= MODE_RESET;
         debounce_ff  <= DEBOUNCE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_wdata[THR_BITS-1:0];
            CSR_MODE:      mode_ff      <= csr_wdata[0];
            CSR_DEBOUNCE:  debounce_ff  <= csr_wdata[DEB_BITS-1:0];
            default:       ;
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_word_ff <= req_tdata[REQ_BITS-1:0];
      end
      if (step_go) begin
         out_word_ff <= step_rsp;
      end
   end

   // A word without an event carries zero key code and modifiers.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[7:1] == 7'd0)
      else $error("non-event result word carries nonzero fields");

   // Event key codes stay within the defined set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> out_word_ff.key_code == EV_ENTER ||
         out_word_ff.key_code == EV_UP || out_word_ff.key_code == EV_DOWN ||
         out_word_ff.key_code == EV_LEFT || out_word_ff.key_code == EV_RIGHT)
      else $error("result key code out of range");

   // Changing the mode leaves both accumulators cleared.
   assert property (@(posedge clock) disable iff (reset)
      mode_clear |=> acc_x_ff == '0 && acc_y_ff == '0)
      else $error("accumulators not cleared after mode change");

   // A held input word that cannot step keeps the input side stalled.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted while the held word is stalled");

endmodule : trackball_direction_events_top

`default_nettype wire

// ===== bench/tb_trackball_direction_events_top.sv =====
// Self-checking testbench for the trackball direction event block.
`timescale 1ns / 100ps

module tb_trackball_direction_events_top
   import tbde_pkg::*;
();

   localparam int unsigned ACC_W = ACC_BITS_DEFAULT;
   // Index 3 has no register behind it; writes there must be ignored.
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int PHASES = 8;
   localparam int PHASE_WORDS = 180;
   localparam int HOLD_OFF_CYCLES = 250;

   // Predicts the key event of every accepted poll word and checks result words.
   class key_event_board;
      logic [THR_BITS-1:0] threshold;
      logic                mode;
      logic [DEB_BITS-1:0] debounce;
      bit                  held;
      bit                  fired;
      logic [31:0]         start_ms;
      bit                  first_level_poll;
      logic [3:0]          last_lv;
      longint              acc_x;
      longint              acc_y;
      rsp_type             pending_events[$];
      int                  fails;

      function new();
         threshold = THRESHOLD_RESET;
         mode = MODE_RESET;
         debounce = DEBOUNCE_RESET;
         held = 0;
         fired = 0;
         start_ms = '0;
         first_level_poll = 1;
         last_lv = '0;
         acc_x = 0;
         acc_y = 0;
         fails = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] val);
         if (idx == CSR_THRESHOLD) begin
            threshold = val[THR_BITS-1:0];
         end else if (idx == CSR_MODE) begin
            // A write of the current mode leaves the accumulators alone.
            if (val[0] != mode) begin
               acc_x = 0;
               acc_y = 0;
               mode = val[0];
            end
         end else if (idx == CSR_DEBOUNCE) begin
            debounce = val;
         end
      endfunction

      function longint sat_add(longint a, longint d);
         longint hi;
         longint lo;
         longint s;
         hi = (longint'(1) << (ACC_W - 1)) - 1;
         lo = -hi - 1;
         s = a + d;
         if (s > hi) s = hi;
         if (s < lo) s = lo;
         return s;
      endfunction

      function void push_event(bit valid, key_type code, logic [3:0] mods);
         rsp_type r;
         r = '0;
         if (valid) begin
            r.event_valid = 1'b1;
            r.key_code = code;
            r.event_modifiers = mods;
         end
         pending_events.push_back(r);
      endfunction

      function void predict_poll(req_type p);
         logic [3:0]  lv;
         logic [3:0]  edges;
         logic [31:0] hold_ms;
         bit          click_evt;
         longint      th;
         longint      dx;
         longint      dy;
         lv = {p.right_level, p.left_level, p.down_level, p.up_level};
         click_evt = 0;
         th = longint'(threshold);
         hold_ms = p.now_ms - start_ms;

         // Click debounce runs on every poll in both modes.
         if (p.click_down) begin
            if (!held) begin
               held = 1;
               start_ms = p.now_ms;
               fired = 0;
            end else if (!fired && hold_ms >= {24'd0, debounce}) begin
               fired = 1;
               click_evt = 1;
            end
         end else begin
            held = 0;
            fired = 0;
         end

         if (mode) begin
            if (click_evt) begin
               push_event(1'b1, EV_ENTER, p.modifier_flags);
               return;
            end
            dy = longint'(p.down_pulses) - longint'(p.up_pulses);
            dx = longint'(p.right_pulses) - longint'(p.left_pulses);
         end else begin
            // The first level poll only records the line levels.
            if (first_level_poll) begin
               first_level_poll = 0;
               last_lv = lv;
               push_event(1'b0, EV_ENTER, '0);
               return;
            end
            edges = lv & ~last_lv;
            last_lv = lv;
            if (click_evt) begin
               push_event(1'b1, EV_ENTER, p.modifier_flags);
               return;
            end
            dy = longint'(edges[1]) - longint'(edges[0]);
            dx = longint'(edges[3]) - longint'(edges[2]);
         end
         acc_y = sat_add(acc_y, dy);
         acc_x = sat_add(acc_x, dx);

         // Direction checks in fixed order; only the firing axis is cleared.
         if (acc_y <= -th) begin
            acc_y = 0;
            push_event(1'b1, EV_UP, p.modifier_flags);
         end else if (acc_y >= th) begin
            acc_y = 0;
            push_event(1'b1, EV_DOWN, p.modifier_flags);
         end else if (acc_x <= -th) begin
            acc_x = 0;
            push_event(1'b1, EV_LEFT, p.modifier_flags);
         end else if (acc_x >= th) begin
            acc_x = 0;
            push_event(1'b1, EV_RIGHT, p.modifier_flags);
         end else begin
            push_event(1'b0, EV_ENTER, '0);
         end
      endfunction

      function void check_event(logic [8*RSP_BYTES-1:0] word);
         rsp_type got;
         rsp_type want;
         got = rsp_type'(word);
         if (pending_events.size() == 0) begin
            $error("result word 0x%02h arrived with no poll outstanding", word);
            fails++;
            return;
         end
         want = pending_events.pop_front();
         if (got.event_valid !== want.event_valid) begin
            $error("event_valid: expected %0d, actual %0d", want.event_valid, got.event_valid);
            fails++;
         end
         if (got.key_code !== want.key_code) begin
            $error("key_code: expected %0d, actual %0d", want.key_code, got.key_code);
            fails++;
         end
         if (got.event_modifiers !== want.event_modifiers) begin
            $error("event_modifiers: expected %0h, actual %0h",
                   want.event_modifiers, got.event_modifiers);
            fails++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [8*REQ_BYTES-1:0]   req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [8*RSP_BYTES-1:0]   rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [1:0]               csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   key_event_board board = new();
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          hold_request = 0;
   logic [31:0] cur_ms = 32'd0;
   bit          click_state = 0;
   int          click_run = 0;

   trackball_direction_events_top #(
      .ACC_BITS(ACC_W)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard limit on the run.
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Result side: random stalls, long hold-offs on request, and checking.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_event(rsp_tdata);
      end
   end

   function automatic req_type make_poll(logic [31:0] t, logic click, logic [3:0] lv,
                                         logic [14:0] pu, logic [14:0] pd,
                                         logic [14:0] pl, logic [14:0] pr,
                                         logic [3:0] mods);
      req_type p;
      p.now_ms = t;
      p.click_down = click;
      p.up_level = lv[0];
      p.down_level = lv[1];
      p.left_level = lv[2];
      p.right_level = lv[3];
      p.up_pulses = pu;
      p.down_pulses = pd;
      p.left_pulses = pl;
      p.right_pulses = pr;
      p.modifier_flags = mods;
      return p;
   endfunction

   function automatic logic [14:0] random_pulses();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return 15'($urandom_range(0, 3));
      if (r < 17) return 15'($urandom_range(0, 32767));
      return (r == 17) ? 15'd0 : 15'h7FFF;
   endfunction

   // Polls follow a plausible timeline: mostly small time steps and click holds.
   function automatic req_type make_random_poll();
      int  r;
      logic click;
      r = $urandom_range(0, 19);
      if (r == 0) cur_ms = $urandom();
      else if (r == 1) cur_ms = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
      else if (r == 2) cur_ms = cur_ms + 32'($urandom_range(200, 300));
      else cur_ms = cur_ms + 32'($urandom_range(0, 12));
      if (click_run == 0) begin
         click_state = !click_state;
         click_run = click_state ? $urandom_range(1, 25) : $urandom_range(1, 8);
      end
      click_run--;
      click = ($urandom_range(0, 14) == 0) ? 1'($urandom_range(0, 1)) : click_state;
      return make_poll(cur_ms, click, 4'($urandom_range(0, 15)), random_pulses(),
                       random_pulses(), random_pulses(), random_pulses(),
                       4'($urandom_range(0, 15)));
   endfunction

   // Offer one poll word with optional idle cycles ahead of it.
   task automatic send_poll(req_type p);
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, p};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.predict_poll(p);
   endtask

   // Stop offering and wait until every outstanding result has been checked.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_events.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Main stimulus.
   initial begin
      int   ph;
      int   n;
      int   k;
      logic [7:0] v;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Click held in pulse mode, then the first level poll spends the fire.
      write_csr(CSR_MODE, 8'd1);
      send_poll(make_poll(32'd100, 1'b1, 4'h0, 15'd0, 15'd0, 15'd0, 15'd0, 4'h1));
      wait_drained();
      write_csr(CSR_MODE, 8'd0);
      send_poll(make_poll(32'd200, 1'b1, 4'h0, 15'd0, 15'd0, 15'd0, 15'd0, 4'h2));
      send_poll(make_poll(32'd300, 1'b1, 4'h1, 15'd0, 15'd0, 15'd0, 15'd0, 4'h3));
      // Three up edges reach the default threshold.
      send_poll(make_poll(32'd301, 1'b0, 4'h0, 15'd0, 15'd0, 15'd0, 15'd0, 4'h4));
      send_poll(make_poll(32'd302, 1'b0, 4'h1, 15'd0, 15'd0, 15'd0, 15'd0, 4'h5));
      send_poll(make_poll(32'd303, 1'b0, 4'h0, 15'd0, 15'd0, 15'd0, 15'd0, 4'h6));
      send_poll(make_poll(32'd304, 1'b0, 4'h1, 15'd0, 15'd0, 15'd0, 15'd0, 4'hF));
      // Debounce just short of and exactly at the hold time.
      send_poll(make_poll(32'd305, 1'b1, 4'hF, 15'd0, 15'd0, 15'd0, 15'd0, 4'h7));
      send_poll(make_poll(32'd334, 1'b1, 4'h0, 15'd0, 15'd0, 15'd0, 15'd0, 4'h8));
      send_poll(make_poll(32'd335, 1'b1, 4'h0, 15'd0, 15'd0, 15'd0, 15'd0, 4'hA));
      send_poll(make_poll(32'd336, 1'b1, 4'h0, 15'd0, 15'd0, 15'd0, 15'd0, 4'h9));
      wait_drained();

      // Threshold zero and zero debounce.
      write_csr(CSR_THRESHOLD, 8'd0);
      write_csr(CSR_DEBOUNCE, 8'd0);
      write_csr(CSR_SPARE, 8'hFF);
      send_poll(make_poll(32'd400, 1'b1, 4'h0, 15'd0, 15'd0, 15'd0, 15'd0, 4'hB));
      send_poll(make_poll(32'd400, 1'b1, 4'h0, 15'd0, 15'd0, 15'd0, 15'd0, 4'hC));
      send_poll(make_poll(32'd401, 1'b0, 4'h0, 15'd0, 15'd0, 15'd0, 15'd0, 4'hD));
      wait_drained();

      // Pulse mode with the largest counts: saturation and a click across the time wrap.
      write_csr(CSR_THRESHOLD, 8'd127);
      write_csr(CSR_DEBOUNCE, 8'd255);
      write_csr(CSR_MODE, 8'd1);
      write_csr(CSR_MODE, 8'd1);
      for (k = 0; k < 5; k++)
         send_poll(make_poll(32'hFFFF_FFF0 + 32'(k), 1'b1, 4'hF, 15'd0, 15'h7FFF,
                             15'd0, 15'h7FFF, 4'h3));
      send_poll(make_poll(32'h0000_00EF, 1'b1, 4'h0, 15'd0, 15'h7FFF, 15'd0, 15'h7FFF,
                          4'h5));
      send_poll(make_poll(32'h0000_00F0, 1'b0, 4'h0, 15'd0, 15'd0, 15'd0, 15'd0, 4'h6));
      for (k = 0; k < 5; k++)
         send_poll(make_poll(32'h100 + 32'(k), 1'b0, 4'h0, 15'h7FFF, 15'd0, 15'h7FFF,
                             15'd0, 4'h9));
      send_poll(make_poll(32'h0000_0110, 1'b0, 4'h0, 15'd0, 15'd0, 15'd0, 15'd0, 4'hE));
      wait_drained();

      // Random phases, each with its own setting and idling pattern.
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 49; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 49; end
            default: begin send_idle_pct = 12; rsp_stall_pct = 12; end
         endcase
         case ($urandom_range(0, 5))
            0: v = 8'd0;
            1: v = 8'd1;
            2: v = 8'd127;
            5: v = 8'($urandom_range(0, 255));
            default: v = 8'($urandom_range(1, 6));
         endcase
         write_csr(CSR_THRESHOLD, v);
         write_csr(CSR_MODE, 8'($urandom_range(0, 255)));
         case ($urandom_range(0, 3))
            0: v = 8'd0;
            1: v = 8'd255;
            2: v = 8'($urandom_range(0, 40));
            default: v = 8'($urandom_range(0, 255));
         endcase
         write_csr(CSR_DEBOUNCE, v);
         if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE, 8'($urandom_range(0, 255)));

         for (n = 0; n < PHASE_WORDS; n++) begin
            // Long result hold-off while polls keep coming, so the input backs up.
            if (ph == 0 && n == 40) hold_request = HOLD_OFF_CYCLES;
            // Sender pause until everything outstanding has come back.
            if (n == 100) wait_drained();
            send_poll(make_random_poll());
         end
         wait_drained();
      end

      // Final drain and verdict.
      req_tvalid <= 1'b0;
      while (board.pending_events.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.pending_events.size() != 0) begin
         $error("%0d expected results never arrived", board.pending_events.size());
      end
      if (board.fails == 0 && board.pending_events.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tbde_pkg.sv
hdl/tbde_step.sv
hdl/trackball_direction_events_top.sv
bench/tb_trackball_direction_events_top.sv
